@@ rtl/palindromic_subsequence_count_macros.svh @@
// ----------------------------------------------------------------------------
// Palindromic subsequence counter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PALINDROMIC_SUBSEQUENCE_COUNT_MACROS_SVH
`define PALINDROMIC_SUBSEQUENCE_COUNT_MACROS_SVH

// same-cycle implication
`define PSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Types shared by the palindromic subsequence counter modules.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned CountW = 64;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            start_req;
  } psc_in_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              full_res;
  } psc_out_t;

  typedef enum logic [1:0] {
    PSC_IDLE,
    PSC_WALK,
    PSC_FINISH
  } psc_state_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic load_out;
  } psc_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } psc_sts_t;

endpackage

@@ rtl/psc_ram.sv @@
// ----------------------------------------------------------------------------
// psc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module psc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/psc_ctrl.sv @@
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer: input transfer, column walk, result hand-off.
// ----------------------------------------------------------------------------
`include "palindromic_subsequence_count_macros.svh"

module psc_ctrl
  import psc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output psc_cmd_t cmd_o,
  input  psc_sts_t sts_i
);

  psc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PSC_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    out_valid_d    = out_valid_q && !out_ready_i;
    case (state_q)
      PSC_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.full || sts_i.empty) begin
            state_d = PSC_FINISH;
          end else begin
            state_d = PSC_WALK;
          end
        end
      end
      PSC_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = PSC_FINISH;
        end
      end
      PSC_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = PSC_IDLE;
        end
      end
      default: begin
        state_d = PSC_IDLE;
      end
    endcase
  end

  `PSC_ASSERT_NOW(a_load_free, cmd_o.load_out, !out_valid_q || out_ready_i, "result overwritten")
  `PSC_ASSERT_NEXT(a_walk_entry, cmd_o.accept && !sts_i.full && !sts_i.empty, state_q == PSC_WALK, "walk not started")
  `PSC_ASSERT_NEXT(a_walk_exit, state_q == PSC_WALK && sts_i.last, state_q == PSC_FINISH, "walk overran")
  `PSC_ASSERT_NOW(a_out_drop, $fell(out_valid_q), $past(out_ready_i), "result lost")

endmodule

@@ rtl/psc_dp.sv @@
// ----------------------------------------------------------------------------
// psc_dp
// Column store, string store and the interval recurrence update.
// ----------------------------------------------------------------------------
module psc_dp
  import psc_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  psc_in_t  in_data_i,
  output psc_out_t out_data_o,
  input  psc_cmd_t cmd_i,
  output psc_sts_t sts_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0]     len_q, len_d, eff_len;
  logic [AW-1:0]     idx_q, raddr, cnt_waddr;
  logic [SymW-1:0]   sym_q, text_rd;
  logic [CountW-1:0] old_right_q, new_right_q, count_q, cnt_rd, cnt_wdata, v;
  logic              full_q, text_we, cnt_we;
  psc_out_t          out_q;

  assign eff_len    = in_data_i.start_req ? '0 : len_q;
  assign sts_o.full  = (eff_len == LW'(MAX_LEN));
  assign sts_o.empty = (eff_len == '0);
  assign sts_o.last  = (idx_q == '0);

  assign text_we   = cmd_i.accept && !sts_o.full;
  assign cnt_we    = text_we || cmd_i.step;
  assign cnt_waddr = cmd_i.step ? idx_q : eff_len[AW-1:0];
  assign cnt_wdata = cmd_i.step ? v : CountW'(1);
  assign raddr     = cmd_i.accept ? (eff_len[AW-1:0] - AW'(1)) : (idx_q - AW'(1));

  // match: 1 + new[i+1] + old[i]; mismatch: new[i+1] + old[i] - old[i+1]
  assign v = (text_rd == sym_q) ? (new_right_q + cnt_rd + CountW'(1))
                                : (new_right_q + cnt_rd - old_right_q);

  psc_ram #(.WIDTH(SymW), .DEPTH(MAX_LEN)) u_text (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (eff_len[AW-1:0]),
    .wdata_i (in_data_i.symbol),
    .raddr_i (raddr),
    .rdata_o (text_rd)
  );

  psc_ram #(.WIDTH(CountW), .DEPTH(MAX_LEN)) u_col (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (raddr),
    .rdata_o (cnt_rd)
  );

  always_comb begin
    len_d = len_q;
    if (text_we) begin
      len_d = eff_len + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sym_q       <= in_data_i.symbol;
      idx_q       <= eff_len[AW-1:0] - AW'(1);
      old_right_q <= '0;
      new_right_q <= CountW'(1);
      full_q      <= sts_o.full;
      if (!sts_o.full && sts_o.empty) begin
        count_q <= CountW'(1);
      end
    end
    if (cmd_i.step) begin
      idx_q       <= idx_q - AW'(1);
      old_right_q <= cnt_rd;
      new_right_q <= v;
      if (sts_o.last) begin
        count_q <= v;
      end
    end
    if (cmd_i.load_out) begin
      out_q.count    <= count_q;
      out_q.full_res <= full_q;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/palindromic_subsequence_count.sv @@
// ----------------------------------------------------------------------------
// palindromic_subsequence_count
// Streaming palindromic subsequence counter over a stored prefix.
// ----------------------------------------------------------------------------
// Each accepted symbol is appended to the stored string (start_req restarts
// it) and the block returns the palindromic subsequence count of the whole
// prefix, modulo 2^64. Between one input transfer and the next, the block
// takes the symbol, then for a symbol at position j the column walk updates
// j stored counts, one per cycle, through the single read port of the column
// RAM, then the result goes to the output register once that register is
// free. The first symbol of a string and a symbol dropped at capacity skip
// the column walk. A new symbol may be taken while the previous result still
// waits in the output register.
module palindromic_subsequence_count
  import psc_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  psc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output psc_out_t out_data_o
);

  psc_cmd_t cmd;
  psc_sts_t sts;

  psc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  psc_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
